### sv/wshd_pkg.sv
// Shared types and constants of the window stack, hit test and drag manager.
// Payload structs for the channels, request/event codes, controller/datapath
// command and status structs. No dependencies.
package wshd_pkg;

  localparam int WIN_COUNT     = 3;
  localparam int SLOT_W        = 2;
  localparam int COORD_W       = 12;
  localparam int SCOORD_W      = 14;
  localparam int SIZE_W        = 8;
  localparam int OWNER_W       = 16;

  localparam int MAX_WIDTH     = 200;
  localparam int MAX_HEIGHT    = 150;
  localparam int TITLE_HEIGHT  = 20;
  localparam int BUTTON_SIZE   = 16;
  localparam int BUTTON_MARGIN = 2;

  localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 12'd1024;
  localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 12'd768;
  localparam logic [COORD_W-1:0] RESERVED_TOP_RST  = 12'd480;

  typedef logic [COORD_W-1:0]         coord_t;
  typedef logic signed [SCOORD_W-1:0] scoord_t;
  typedef logic [SLOT_W-1:0]          slot_t;

  typedef enum logic [2:0] {
    REQ_CLICK   = 3'd0,
    REQ_DRAG    = 3'd1,
    REQ_RELEASE = 3'd2,
    REQ_REDRAW  = 3'd3,
    REQ_LOAD    = 3'd4
  } req_type_e;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_LOADED     = 3'd1,
    EV_RAISED     = 3'd2,
    EV_DRAG_START = 3'd3,
    EV_MOVED      = 3'd4,
    EV_CLOSED     = 3'd5,
    EV_DRAG_END   = 3'd6,
    EV_REDRAW     = 3'd7
  } event_e;

  typedef enum logic [1:0] {
    REGION_CANVAS = 2'd0,
    REGION_TITLE  = 2'd1,
    REGION_CLOSE  = 2'd2
  } region_e;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_RESERVED_TOP  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]         req_type;
    coord_t             pos_x;
    coord_t             pos_y;
    logic [1:0]         load_index;
    coord_t             req_width;
    coord_t             req_height;
    logic [OWNER_W-1:0] load_owner;
  } req_t;

  typedef struct packed {
    logic [2:0]         event_code;
    logic [1:0]         window_index;
    coord_t             new_x;
    coord_t             new_y;
    coord_t             old_x;
    coord_t             old_y;
    logic               erase_old;
    logic               recomposite;
    logic [5:0]         stack_order;
    logic [2:0]         open_mask;
    logic [OWNER_W-1:0] owner_out;
  } rsp_t;

  typedef struct packed {
    logic [1:0]   index;
    coord_t       data;
  } cfg_t;

  typedef struct packed {
    logic  take_req;
    logic  scan;
    slot_t scan_pos;
    logic  apply;
    logic  report;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_click;
    logic hit_now;
  } dp_status_t;

  // zero-extend a screen coordinate into the signed compare domain
  function automatic scoord_t widen(coord_t v);
    return scoord_t'({{(SCOORD_W-COORD_W){1'b0}}, v});
  endfunction

endpackage

### sv/wshd_stream_if.sv
// Valid/ready channel carrying one payload struct.
// Payload type comes from wshd_pkg at the point of instantiation.
interface wshd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/wshd_ctrl.sv
// Sequencing FSM: accept, z-order scan, apply, report into the output slot.
// Depends on wshd_pkg for the command/status structs.
module wshd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  output logic                   rsp_valid_o,
  input  logic                   rsp_ready_i,
  input  wshd_pkg::dp_status_t   status_i,
  output wshd_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_REPORT
  } state_e;

  state_e              state_q, state_d;
  wshd_pkg::slot_t     pos_q, pos_d;
  logic                out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    out_valid_d   = out_valid_q;
    req_ready_o   = 1'b0;
    cmd_o         = '0;
    cmd_o.scan_pos = pos_q;

    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.take_req = 1'b1;
          pos_d          = wshd_pkg::SLOT_W'(wshd_pkg::WIN_COUNT - 1);
          state_d        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // top of the stack first, stop at the first hit
        cmd_o.scan = 1'b1;
        if (!status_i.is_click || status_i.hit_now || pos_q == '0) begin
          state_d = ST_APPLY;
        end else begin
          pos_d = pos_q - 1'b1;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_REPORT;
      end
      ST_REPORT: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.report = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

### sv/wshd_dp.sv
// Datapath: window table, z-order, drag record, config registers, the
// shared hit tester, drag clamp and the output register. Uses wshd_pkg.
module wshd_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wshd_pkg::req_t        req_i,
  input  logic                  cfg_we_i,
  input  wshd_pkg::cfg_t        cfg_i,
  input  wshd_pkg::ctrl_cmd_t   cmd_i,
  output wshd_pkg::dp_status_t  status_o,
  output wshd_pkg::rsp_t        rsp_o
);

  localparam int N = wshd_pkg::WIN_COUNT;
  localparam int SW = wshd_pkg::SLOT_W;
  localparam int CW = wshd_pkg::COORD_W;
  localparam int ZW = wshd_pkg::SIZE_W;
  localparam int OW = wshd_pkg::OWNER_W;

  localparam wshd_pkg::scoord_t MW_S  = wshd_pkg::scoord_t'(wshd_pkg::MAX_WIDTH);
  localparam wshd_pkg::scoord_t TH_S  = wshd_pkg::scoord_t'(wshd_pkg::TITLE_HEIGHT);
  localparam wshd_pkg::scoord_t BS_S  = wshd_pkg::scoord_t'(wshd_pkg::BUTTON_SIZE);
  localparam wshd_pkg::scoord_t BDX_S = wshd_pkg::scoord_t'(wshd_pkg::MAX_WIDTH
                                        - wshd_pkg::BUTTON_MARGIN - wshd_pkg::BUTTON_SIZE);
  localparam wshd_pkg::scoord_t BDY_S = wshd_pkg::scoord_t'(
      (wshd_pkg::TITLE_HEIGHT - wshd_pkg::BUTTON_SIZE) / 2 - wshd_pkg::TITLE_HEIGHT);

  // window table and stack
  logic [CW-1:0]        win_x_q [N];
  logic [CW-1:0]        win_x_d [N];
  logic [CW-1:0]        win_y_q [N];
  logic [CW-1:0]        win_y_d [N];
  logic [ZW-1:0]        win_w_q [N];
  logic [ZW-1:0]        win_w_d [N];
  logic [ZW-1:0]        win_h_q [N];
  logic [ZW-1:0]        win_h_d [N];
  logic [OW-1:0]        win_own_q [N];
  logic [OW-1:0]        win_own_d [N];
  logic [N-1:0]         closed_q, closed_d;
  wshd_pkg::slot_t      stack_q [N];
  wshd_pkg::slot_t      stack_d [N];

  logic                 drag_active_q, drag_active_d;
  wshd_pkg::slot_t      drag_slot_q, drag_slot_d;
  wshd_pkg::scoord_t    grab_dx_q, grab_dx_d;
  wshd_pkg::scoord_t    grab_dy_q, grab_dy_d;

  wshd_pkg::coord_t     scr_w_q, scr_h_q, rsv_top_q;

  // per-request working registers
  wshd_pkg::req_t       req_q;
  logic                 hit_found_q;
  wshd_pkg::slot_t      hit_pos_q, hit_slot_q;
  wshd_pkg::region_e    hit_region_q;
  wshd_pkg::rsp_t       res_q, res_d;
  wshd_pkg::rsp_t       rsp_q;
  wshd_pkg::rsp_t       rsp_fill;

  // single table read port
  wshd_pkg::slot_t      rd_slot;
  wshd_pkg::coord_t     rd_x, rd_y;
  logic [ZW-1:0]        rd_w, rd_h;
  logic [OW-1:0]        rd_owner;
  logic                 rd_closed;
  logic                 is_click;

  wshd_pkg::scoord_t    px_s, py_s, wx_s, wy_s, ww_s, wh_s;
  logic                 btn_hit, title_hit, canvas_hit;
  wshd_pkg::region_e    region_now;
  logic                 hit_now;

  wshd_pkg::scoord_t    x0, x1, x2, x3, xlim;
  wshd_pkg::scoord_t    y0, y1, y2, y3, ylim, miny;
  wshd_pkg::slot_t      load_pos;
  logic [5:0]           stack_vec;

  assign is_click = (req_q.req_type == wshd_pkg::REQ_CLICK);

  always_comb begin
    if (cmd_i.scan) begin
      rd_slot = stack_q[cmd_i.scan_pos];
    end else if (is_click) begin
      rd_slot = hit_slot_q;
    end else begin
      rd_slot = drag_slot_q;
    end
  end

  assign rd_x      = win_x_q[rd_slot];
  assign rd_y      = win_y_q[rd_slot];
  assign rd_w      = win_w_q[rd_slot];
  assign rd_h      = win_h_q[rd_slot];
  assign rd_owner  = win_own_q[rd_slot];
  assign rd_closed = closed_q[rd_slot];

  // hit test of one window
  assign px_s = wshd_pkg::widen(req_q.pos_x);
  assign py_s = wshd_pkg::widen(req_q.pos_y);
  assign wx_s = wshd_pkg::widen(rd_x);
  assign wy_s = wshd_pkg::widen(rd_y);
  assign ww_s = wshd_pkg::widen(CW'(rd_w));
  assign wh_s = wshd_pkg::widen(CW'(rd_h));

  assign btn_hit    = (px_s >= wx_s + BDX_S) && (px_s < wx_s + BDX_S + BS_S)
                   && (py_s >= wy_s + BDY_S) && (py_s < wy_s + BDY_S + BS_S);
  assign title_hit  = (px_s >= wx_s) && (px_s < wx_s + MW_S)
                   && (py_s >= wy_s - TH_S) && (py_s < wy_s);
  assign canvas_hit = (px_s >= wx_s) && (px_s < wx_s + ww_s)
                   && (py_s >= wy_s) && (py_s < wy_s + wh_s);

  always_comb begin
    if (btn_hit) begin
      region_now = wshd_pkg::REGION_CLOSE;
    end else if (title_hit) begin
      region_now = wshd_pkg::REGION_TITLE;
    end else begin
      region_now = wshd_pkg::REGION_CANVAS;
    end
  end

  assign hit_now = is_click && !rd_closed && (btn_hit || title_hit || canvas_hit);

  assign status_o.is_click = is_click;
  assign status_o.hit_now  = hit_now;

  // drag clamp: left edge, right edge, then top bound, bottom bound, zero
  assign x0   = px_s - grab_dx_q;
  assign x1   = (x0 < 0) ? '0 : x0;
  assign xlim = wshd_pkg::widen(scr_w_q) - MW_S;
  assign x2   = (x1 > xlim) ? xlim : x1;
  assign x3   = (x2 < 0) ? '0 : x2;

  assign y0   = py_s - grab_dy_q;
  assign miny = wshd_pkg::widen(rsv_top_q) + TH_S;
  assign y1   = (y0 < miny) ? miny : y0;
  assign ylim = wshd_pkg::widen(scr_h_q) - wh_s;
  assign y2   = (y1 > ylim) ? ylim : y1;
  assign y3   = (y2 < 0) ? '0 : y2;

  always_comb begin
    win_x_d       = win_x_q;
    win_y_d       = win_y_q;
    win_w_d       = win_w_q;
    win_h_d       = win_h_q;
    win_own_d     = win_own_q;
    closed_d      = closed_q;
    stack_d       = stack_q;
    drag_active_d = drag_active_q;
    drag_slot_d   = drag_slot_q;
    grab_dx_d     = grab_dx_q;
    grab_dy_d     = grab_dy_q;
    res_d         = '0;

    load_pos = req_q.load_index;
    for (int i = 0; i < N; i++) begin
      if (stack_q[i] == req_q.load_index) begin
        load_pos = SW'(i);
      end
    end

    if (cmd_i.apply) begin
      case (req_q.req_type)
        wshd_pkg::REQ_CLICK: begin
          if (hit_found_q) begin
            res_d.window_index = hit_slot_q;
            res_d.new_x        = rd_x;
            res_d.new_y        = rd_y;
            case (hit_region_q)
              wshd_pkg::REGION_CLOSE: begin
                res_d.old_x       = rd_x;
                res_d.old_y       = rd_y;
                res_d.erase_old   = 1'b1;
                res_d.recomposite = 1'b1;
                res_d.owner_out   = rd_owner;
                res_d.event_code  = wshd_pkg::EV_CLOSED;
                closed_d[hit_slot_q] = 1'b1;
                if (drag_active_q && drag_slot_q == hit_slot_q) begin
                  drag_active_d = 1'b0;
                end
              end
              wshd_pkg::REGION_TITLE, wshd_pkg::REGION_CANVAS: begin
                // raise: shift the entries above down, hit slot to the top
                if (hit_pos_q < SW'(N - 1)) begin
                  res_d.recomposite = 1'b1;
                  for (int i = 0; i < N - 1; i++) begin
                    if (SW'(i) >= hit_pos_q) begin
                      stack_d[i] = stack_q[i + 1];
                    end
                  end
                  stack_d[N-1] = hit_slot_q;
                end
                if (hit_region_q == wshd_pkg::REGION_TITLE) begin
                  drag_active_d    = 1'b1;
                  drag_slot_d      = hit_slot_q;
                  grab_dx_d        = px_s - wx_s;
                  grab_dy_d        = py_s - wy_s;
                  res_d.event_code = wshd_pkg::EV_DRAG_START;
                end else begin
                  res_d.event_code = wshd_pkg::EV_RAISED;
                end
              end
              default: begin
                res_d.event_code = wshd_pkg::EV_NONE;
              end
            endcase
          end
        end
        wshd_pkg::REQ_DRAG: begin
          if (drag_active_q) begin
            win_x_d[drag_slot_q] = x3[CW-1:0];
            win_y_d[drag_slot_q] = y3[CW-1:0];
            res_d.window_index   = drag_slot_q;
            res_d.new_x          = x3[CW-1:0];
            res_d.new_y          = y3[CW-1:0];
            res_d.old_x          = rd_x;
            res_d.old_y          = rd_y;
            res_d.erase_old      = 1'b1;
            res_d.recomposite    = 1'b1;
            res_d.event_code     = wshd_pkg::EV_MOVED;
          end
        end
        wshd_pkg::REQ_RELEASE: begin
          if (drag_active_q) begin
            drag_active_d      = 1'b0;
            res_d.window_index = drag_slot_q;
            res_d.new_x        = rd_x;
            res_d.new_y        = rd_y;
            res_d.event_code   = wshd_pkg::EV_DRAG_END;
          end
        end
        wshd_pkg::REQ_REDRAW: begin
          res_d.recomposite = 1'b1;
          res_d.event_code  = wshd_pkg::EV_REDRAW;
        end
        wshd_pkg::REQ_LOAD: begin
          if (req_q.load_index < SW'(N)) begin
            win_x_d[req_q.load_index]   = req_q.pos_x;
            win_y_d[req_q.load_index]   = req_q.pos_y;
            win_w_d[req_q.load_index]   = (req_q.req_width < CW'(wshd_pkg::MAX_WIDTH))
                                          ? req_q.req_width[ZW-1:0]
                                          : ZW'(wshd_pkg::MAX_WIDTH);
            win_h_d[req_q.load_index]   = (req_q.req_height < CW'(wshd_pkg::MAX_HEIGHT))
                                          ? req_q.req_height[ZW-1:0]
                                          : ZW'(wshd_pkg::MAX_HEIGHT);
            win_own_d[req_q.load_index] = req_q.load_owner;
            closed_d[req_q.load_index]  = 1'b0;
            // swap z positions with whatever sits at position load_index
            stack_d[load_pos]          = stack_q[req_q.load_index];
            stack_d[req_q.load_index]  = req_q.load_index;
            res_d.window_index = req_q.load_index;
            res_d.new_x        = req_q.pos_x;
            res_d.new_y        = req_q.pos_y;
            res_d.recomposite  = 1'b1;
            res_d.event_code   = wshd_pkg::EV_LOADED;
          end
        end
        default: begin
          res_d.event_code = wshd_pkg::EV_NONE;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      stack_vec[2*i +: 2] = stack_q[i];
    end
  end

  // report value: event fields from apply, stack and open mask as they stand
  always_comb begin
    rsp_fill             = res_q;
    rsp_fill.stack_order = stack_vec;
    rsp_fill.open_mask   = ~closed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        win_x_q[i]   <= '0;
        win_y_q[i]   <= '0;
        win_w_q[i]   <= '0;
        win_h_q[i]   <= '0;
        win_own_q[i] <= '0;
        stack_q[i]   <= SW'(i);
      end
      closed_q      <= '1;
      drag_active_q <= 1'b0;
      drag_slot_q   <= '0;
      grab_dx_q     <= '0;
      grab_dy_q     <= '0;
      hit_found_q   <= 1'b0;
      scr_w_q       <= wshd_pkg::SCREEN_WIDTH_RST;
      scr_h_q       <= wshd_pkg::SCREEN_HEIGHT_RST;
      rsv_top_q     <= wshd_pkg::RESERVED_TOP_RST;
    end else begin
      win_x_q       <= win_x_d;
      win_y_q       <= win_y_d;
      win_w_q       <= win_w_d;
      win_h_q       <= win_h_d;
      win_own_q     <= win_own_d;
      stack_q       <= stack_d;
      closed_q      <= closed_d;
      drag_active_q <= drag_active_d;
      drag_slot_q   <= drag_slot_d;
      grab_dx_q     <= grab_dx_d;
      grab_dy_q     <= grab_dy_d;
      if (cmd_i.take_req) begin
        hit_found_q <= 1'b0;
      end else if (cmd_i.scan && hit_now) begin
        hit_found_q <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_i.index)
          wshd_pkg::CFG_SCREEN_WIDTH:  scr_w_q   <= cfg_i.data;
          wshd_pkg::CFG_SCREEN_HEIGHT: scr_h_q   <= cfg_i.data;
          wshd_pkg::CFG_RESERVED_TOP:  rsv_top_q <= cfg_i.data;
          default: begin
            rsv_top_q <= rsv_top_q;
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_req) begin
      req_q <= req_i;
    end
    if (cmd_i.scan && hit_now) begin
      hit_pos_q    <= cmd_i.scan_pos;
      hit_slot_q   <= rd_slot;
      hit_region_q <= region_now;
    end
    if (cmd_i.apply) begin
      res_q <= res_d;
    end
    if (cmd_i.report) begin
      rsp_q <= rsp_fill;
    end
  end

  assign rsp_o = rsp_q;

endmodule

### sv/window_stack_hit_drag_manager_core.sv
// Top level of the window stack, hit test and drag manager.
// Uses wshd_pkg, wshd_stream_if, wshd_ctrl and wshd_dp.
//
//  channel | dir | payload            | transfer when
//  --------+-----+--------------------+---------------------------
//  req_i   | in  | wshd_pkg::req_t    | req_i.valid && req_i.ready
//  rsp_o   | out | wshd_pkg::rsp_t    | rsp_o.valid && rsp_o.ready
//  cfg_i   | in  | wshd_pkg::cfg_t    | cfg_i.valid && cfg_i.ready
//
// One request at a time. After a transfer the controller steps through scan,
// apply and report before it is ready again; a click scans the windows one at
// a time, walking the z-order from the top down until the first hit.
// The result lands in an output register, so a new request is taken while
// it waits; only the report step stalls when that register is still full.
// Reset (async, active low): all windows closed, identity z-order, no drag,
// config registers at 1024 / 768 / 480. cfg_i is always ready.
module window_stack_hit_drag_manager_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  wshd_stream_if.sink   req_i,
  wshd_stream_if.source rsp_o,
  wshd_stream_if.sink   cfg_i
);

  wshd_pkg::ctrl_cmd_t  cmd;
  wshd_pkg::dp_status_t status;
  wshd_pkg::req_t       req_payload;
  wshd_pkg::cfg_t       cfg_payload;
  wshd_pkg::rsp_t       rsp_payload;
  logic                 req_ready;
  logic                 rsp_valid;
  logic                 cfg_we;

  assign req_payload = req_i.payload;
  assign cfg_payload = cfg_i.payload;

  // config writes land directly, block is idle by contract
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  wshd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wshd_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_payload),
    .cfg_we_i (cfg_we),
    .cfg_i    (cfg_payload),
    .cmd_i    (cmd),
    .status_o (status),
    .rsp_o    (rsp_payload)
  );

  assign req_i.ready   = req_ready;
  assign rsp_o.valid   = rsp_valid;
  assign rsp_o.payload = rsp_payload;

  // a request is never taken in back-to-back cycles: the scan always follows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while previous one in flight");

  // a result only becomes visible out of a report step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.report))
    else $error("result valid without report step");

  // a loaded window is reported open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.payload.event_code == wshd_pkg::EV_LOADED)
      |-> rsp_o.payload.open_mask[rsp_o.payload.window_index])
    else $error("loaded window not open");

  // scan, apply and report never coincide with taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take_req |-> (!cmd.apply && !cmd.report && !cmd.scan))
    else $error("controller commands overlap");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for window_stack_hit_drag_manager_core.
// Depends on wshd_pkg, wshd_stream_if and the core; every report is checked
// against a typed expectation or a built-in predictor, for a directed table and weighted random traffic.
module tb_top;

  // request codes the block does not know; they must come back as no event
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [5:0] ZORDER_RESET  = {2'd2, 2'd1, 2'd0};
  localparam int unsigned RUN_LIMIT    = 200000;
  localparam int PHASE_ITEMS           = 225;

  typedef struct {
    wshd_pkg::req_t rq;
    bit             typed;
    wshd_pkg::rsp_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wshd_stream_if #(.payload_t(wshd_pkg::req_t)) req_if ();
  wshd_stream_if #(.payload_t(wshd_pkg::rsp_t)) rsp_if ();
  wshd_stream_if #(.payload_t(wshd_pkg::cfg_t)) cfg_if ();

  window_stack_hit_drag_manager_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: window table, z-order (bottom first), drag record and
  // the three screen registers.
  // ---------------------------------------------------------------------
  wshd_pkg::coord_t              wx     [wshd_pkg::WIN_COUNT];
  wshd_pkg::coord_t              wy     [wshd_pkg::WIN_COUNT];
  logic [wshd_pkg::SIZE_W-1:0]   ww     [wshd_pkg::WIN_COUNT];
  logic [wshd_pkg::SIZE_W-1:0]   wh     [wshd_pkg::WIN_COUNT];
  logic [wshd_pkg::OWNER_W-1:0]  wowner [wshd_pkg::WIN_COUNT];
  logic [wshd_pkg::WIN_COUNT-1:0] wshut;
  wshd_pkg::slot_t               zorder [wshd_pkg::WIN_COUNT];
  logic                          dragging;
  wshd_pkg::slot_t               drag_win;
  int                            grip_dx, grip_dy;
  wshd_pkg::coord_t              scr_w, scr_h, top_rsv;

  wshd_pkg::rsp_t awaited_reports [$];
  dir_row_t script [$];
  int       mismatches = 0;
  bit       steady = 1'b0;   // both sides run without gaps while set
  int       rsp_hold = 0;    // long hold-off on the report side, in cycles
  int       rsp_gap = 0;
  int unsigned cycle_count = 0;

  // screen settings per random phase; the fourth one is drawn at random
  int settings [5][3] = '{'{640, 700, 0}, '{4095, 4095, 2048}, '{200, 700, 2048},
                          '{1024, 768, 480}, '{1024, 768, 480}};

  function automatic void reset_model();
    for (int i = 0; i < wshd_pkg::WIN_COUNT; i++) begin
      wx[i] = '0;
      wy[i] = '0;
      ww[i] = '0;
      wh[i] = '0;
      wowner[i] = '0;
      zorder[i] = wshd_pkg::slot_t'(i);
    end
    wshut    = '1;
    dragging = 1'b0;
    drag_win = '0;
    grip_dx  = 0;
    grip_dy  = 0;
    scr_w    = wshd_pkg::SCREEN_WIDTH_RST;
    scr_h    = wshd_pkg::SCREEN_HEIGHT_RST;
    top_rsv  = wshd_pkg::RESERVED_TOP_RST;
  endfunction

  // Topmost open window under the pointer, as a z position, or -1.
  // Close button is tested before the title bar, which spans the full
  // MAX_WIDTH whatever the canvas width; title rows above y=0 never match.
  function automatic int locate_hit(input int px, input int py,
                                    output wshd_pkg::region_e area);
    int              x, y, w, h, tt, bx, by;
    wshd_pkg::slot_t s;
    area = wshd_pkg::REGION_CANVAS;
    for (int p = wshd_pkg::WIN_COUNT - 1; p >= 0; p--) begin
      s = zorder[p];
      if (wshut[s]) continue;
      x  = wx[s];
      y  = wy[s];
      w  = ww[s];
      h  = wh[s];
      tt = y - wshd_pkg::TITLE_HEIGHT;
      bx = x + wshd_pkg::MAX_WIDTH - wshd_pkg::BUTTON_MARGIN - wshd_pkg::BUTTON_SIZE;
      by = tt + (wshd_pkg::TITLE_HEIGHT - wshd_pkg::BUTTON_SIZE) / 2;
      if (px >= bx && px < bx + wshd_pkg::BUTTON_SIZE
          && py >= by && py < by + wshd_pkg::BUTTON_SIZE) begin
        area = wshd_pkg::REGION_CLOSE;
        return p;
      end
      if (px >= x && px < x + wshd_pkg::MAX_WIDTH && py >= tt && py < y) begin
        area = wshd_pkg::REGION_TITLE;
        return p;
      end
      if (px >= x && px < x + w && py >= y && py < y + h) begin
        area = wshd_pkg::REGION_CANVAS;
        return p;
      end
    end
    return -1;
  endfunction

  // Rotate the entry at z position p to the top; no change if already there.
  function automatic bit lift_to_top(input int p);
    wshd_pkg::slot_t r;
    if (p >= wshd_pkg::WIN_COUNT - 1) return 1'b0;
    r = zorder[p];
    for (int i = p; i < wshd_pkg::WIN_COUNT - 1; i++) zorder[i] = zorder[i + 1];
    zorder[wshd_pkg::WIN_COUNT - 1] = r;
    return 1'b1;
  endfunction

  // Advance the predictor by one request and return the report it causes.
  function automatic wshd_pkg::rsp_t apply_request(input wshd_pkg::req_t rq);
    wshd_pkg::rsp_t    ev;
    wshd_pkg::region_e area;
    int                p, px, py, nx, ny, miny, sw, sh, hh;
    wshd_pkg::slot_t   s, held;
    ev = '0;
    px = rq.pos_x;
    py = rq.pos_y;
    case (rq.req_type)
      wshd_pkg::REQ_CLICK: begin
        p = locate_hit(px, py, area);
        if (p >= 0) begin
          s = zorder[p];
          ev.window_index = s;
          ev.new_x = wx[s];
          ev.new_y = wy[s];
          if (area == wshd_pkg::REGION_CLOSE) begin
            ev.old_x       = wx[s];
            ev.old_y       = wy[s];
            ev.erase_old   = 1'b1;
            ev.recomposite = 1'b1;
            ev.owner_out   = wowner[s];
            ev.event_code  = wshd_pkg::EV_CLOSED;
            wshut[s] = 1'b1;
            if (dragging && drag_win == s) dragging = 1'b0;   // closing ends its drag
          end else begin
            ev.recomposite = lift_to_top(p);
            if (area == wshd_pkg::REGION_TITLE) begin
              nx = wx[s];
              ny = wy[s];
              dragging = 1'b1;
              drag_win = s;
              grip_dx  = px - nx;
              grip_dy  = py - ny;
              ev.event_code = wshd_pkg::EV_DRAG_START;
            end else begin
              ev.event_code = wshd_pkg::EV_RAISED;
            end
          end
        end
      end
      wshd_pkg::REQ_DRAG: begin
        if (dragging) begin
          s    = drag_win;
          sw   = scr_w;
          sh   = scr_h;
          hh   = wh[s];
          miny = top_rsv;
          miny = miny + wshd_pkg::TITLE_HEIGHT;
          nx   = px - grip_dx;
          ny   = py - grip_dy;
          // x: left edge first, then right edge, negative bound floors at 0
          if (nx < 0) nx = 0;
          if (nx + wshd_pkg::MAX_WIDTH > sw) nx = sw - wshd_pkg::MAX_WIDTH;
          if (nx < 0) nx = 0;
          // y: reserved top first, bottom edge wins over it
          if (ny < miny) ny = miny;
          if (ny + hh > sh) ny = sh - hh;
          if (ny < 0) ny = 0;
          ev.old_x = wx[s];
          ev.old_y = wy[s];
          wx[s] = wshd_pkg::coord_t'(nx);
          wy[s] = wshd_pkg::coord_t'(ny);
          ev.window_index = s;
          ev.new_x        = wx[s];
          ev.new_y        = wy[s];
          ev.erase_old    = 1'b1;
          ev.recomposite  = 1'b1;
          ev.event_code   = wshd_pkg::EV_MOVED;
        end
      end
      wshd_pkg::REQ_RELEASE: begin
        if (dragging) begin
          dragging = 1'b0;
          ev.window_index = drag_win;
          ev.new_x        = wx[drag_win];
          ev.new_y        = wy[drag_win];
          ev.event_code   = wshd_pkg::EV_DRAG_END;
        end
      end
      wshd_pkg::REQ_REDRAW: begin
        ev.event_code  = wshd_pkg::EV_REDRAW;
        ev.recomposite = 1'b1;
      end
      wshd_pkg::REQ_LOAD: begin
        if (rq.load_index < wshd_pkg::WIN_COUNT) begin
          s = rq.load_index;
          wx[s] = rq.pos_x;
          wy[s] = rq.pos_y;
          ww[s] = (rq.req_width < wshd_pkg::MAX_WIDTH)
                  ? rq.req_width[wshd_pkg::SIZE_W-1:0]
                  : wshd_pkg::SIZE_W'(wshd_pkg::MAX_WIDTH);
          wh[s] = (rq.req_height < wshd_pkg::MAX_HEIGHT)
                  ? rq.req_height[wshd_pkg::SIZE_W-1:0]
                  : wshd_pkg::SIZE_W'(wshd_pkg::MAX_HEIGHT);
          wowner[s] = rq.load_owner;
          wshut[s]  = 1'b0;
          // trade z positions with whatever sits at position == slot
          p = s;
          for (int i = 0; i < wshd_pkg::WIN_COUNT; i++) if (zorder[i] == s) p = i;
          held      = zorder[s];
          zorder[s] = zorder[p];
          zorder[p] = held;
          ev.window_index = s;
          ev.new_x        = rq.pos_x;
          ev.new_y        = rq.pos_y;
          ev.recomposite  = 1'b1;
          ev.event_code   = wshd_pkg::EV_LOADED;
        end
      end
      default: ;
    endcase
    ev.stack_order = {zorder[2], zorder[1], zorder[0]};
    ev.open_mask   = ~wshut;
    return ev;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic wshd_pkg::rsp_t report_of(input wshd_pkg::event_e code, input int wi,
                                               input int nx, input int ny, input bit rc,
                                               input logic [5:0] order,
                                               input logic [2:0] open);
    wshd_pkg::rsp_t r;
    r = '0;
    r.event_code   = code;
    r.window_index = wshd_pkg::slot_t'(wi);
    r.new_x        = wshd_pkg::coord_t'(nx);
    r.new_y        = wshd_pkg::coord_t'(ny);
    r.recomposite  = rc;
    r.stack_order  = order;
    r.open_mask    = open;
    return r;
  endfunction

  function automatic void plan(input logic [2:0] kind, input int x, input int y,
                               input int idx = 0, input int w = 0, input int h = 0,
                               input int owner = 0, input bit typed = 1'b0,
                               input wshd_pkg::rsp_t want = '0);
    dir_row_t row;
    row.rq.req_type   = kind;
    row.rq.pos_x      = wshd_pkg::coord_t'(x);
    row.rq.pos_y      = wshd_pkg::coord_t'(y);
    row.rq.load_index = 2'(idx);
    row.rq.req_width  = wshd_pkg::coord_t'(w);
    row.rq.req_height = wshd_pkg::coord_t'(h);
    row.rq.load_owner = wshd_pkg::OWNER_W'(owner);
    row.typed = typed;
    row.want  = want;
    script.push_back(row);
  endfunction

  // Random request, in large part aimed at the windows the predictor knows about so
  // that hits, drags and closes are frequent; the rest is background noise.
  function automatic wshd_pkg::req_t pick_request();
    wshd_pkg::req_t rq;
    int             kind, s, x, y, w, h, ax, ay;
    rq.req_type   = wshd_pkg::REQ_CLICK;
    rq.pos_x      = wshd_pkg::coord_t'($urandom);
    rq.pos_y      = wshd_pkg::coord_t'($urandom);
    rq.load_index = 2'($urandom);
    rq.req_width  = wshd_pkg::coord_t'($urandom);
    rq.req_height = wshd_pkg::coord_t'($urandom);
    rq.load_owner = wshd_pkg::OWNER_W'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      s = $urandom_range(0, wshd_pkg::WIN_COUNT - 1);
      x = wx[s];
      y = wy[s];
      w = ww[s];
      h = wh[s];
      case ($urandom_range(0, 7))
        0: begin   // close button
          ax = x + wshd_pkg::MAX_WIDTH - wshd_pkg::BUTTON_MARGIN - wshd_pkg::BUTTON_SIZE
               + $urandom_range(0, wshd_pkg::BUTTON_SIZE - 1);
          ay = y - wshd_pkg::TITLE_HEIGHT + 2
               + $urandom_range(0, wshd_pkg::BUTTON_SIZE - 1);
        end
        1, 2, 3: begin   // title bar
          ax = x + $urandom_range(0, wshd_pkg::MAX_WIDTH - 1);
          ay = y - wshd_pkg::TITLE_HEIGHT + $urandom_range(0, wshd_pkg::TITLE_HEIGHT - 1);
        end
        4, 5: begin   // canvas
          ax = x + $urandom_range(0, w > 0 ? w - 1 : 0);
          ay = y + $urandom_range(0, h > 0 ? h - 1 : 0);
        end
        6: begin   // around the borders, one pixel out on each side
          ax = x - 1 + $urandom_range(0, wshd_pkg::MAX_WIDTH + 1);
          ay = y - wshd_pkg::TITLE_HEIGHT - 1
               + $urandom_range(0, h + wshd_pkg::TITLE_HEIGHT + 1);
        end
        default: begin   // just past the canvas corner
          ax = x + w;
          ay = y + h;
        end
      endcase
      rq.pos_x = wshd_pkg::coord_t'(ax);
      rq.pos_y = wshd_pkg::coord_t'(ay);
    end else if (kind < 62) begin
      rq.req_type = wshd_pkg::REQ_DRAG;
      if ($urandom_range(0, 1) == 0) begin
        rq.pos_x = wshd_pkg::coord_t'($urandom_range(0, 1100));
        rq.pos_y = wshd_pkg::coord_t'($urandom_range(0, 900));
      end
    end else if (kind < 70) begin
      rq.req_type = wshd_pkg::REQ_RELEASE;
    end else if (kind < 74) begin
      rq.req_type = wshd_pkg::REQ_REDRAW;
    end else if (kind < 88) begin
      rq.req_type   = wshd_pkg::REQ_LOAD;
      rq.load_index = ($urandom_range(0, 9) == 0)
                      ? 2'(wshd_pkg::WIN_COUNT)
                      : 2'($urandom_range(0, wshd_pkg::WIN_COUNT - 1));
      if ($urandom_range(0, 4) != 0) begin
        rq.pos_x = wshd_pkg::coord_t'($urandom_range(0, 1000));
        rq.pos_y = wshd_pkg::coord_t'($urandom_range(0, 800));
      end
      if ($urandom_range(0, 1) == 0) rq.req_width  = wshd_pkg::coord_t'($urandom_range(0, 220));
      if ($urandom_range(0, 1) == 0) rq.req_height = wshd_pkg::coord_t'($urandom_range(0, 170));
    end else if (kind < 95) begin
      rq.req_type = wshd_pkg::REQ_CLICK;   // anywhere on the full coordinate range
    end else begin
      rq.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    end
    return rq;
  endfunction

  // One request transfer; the expectation is queued at the transfer edge.
  task automatic send_request(input wshd_pkg::req_t rq, input bit typed,
                              input wshd_pkg::rsp_t want);
    int             gap;
    wshd_pkg::rsp_t predicted;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= rq;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = apply_request(rq);
    awaited_reports.push_back(typed ? want : predicted);
  endtask

  // Stop offering and wait until every outstanding report has come back.
  task automatic settle();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_reports.size() != 0);
  endtask

  // Write all three screen registers back to back; only called when idle.
  task automatic program_screen(input int w, input int h, input int t);
    wshd_pkg::cfg_t writes [3];
    writes[0] = '{index: wshd_pkg::CFG_SCREEN_WIDTH,  data: wshd_pkg::coord_t'(w)};
    writes[1] = '{index: wshd_pkg::CFG_SCREEN_HEIGHT, data: wshd_pkg::coord_t'(h)};
    writes[2] = '{index: wshd_pkg::CFG_RESERVED_TOP,  data: wshd_pkg::coord_t'(t)};
    cfg_if.valid <= 1'b1;
    foreach (writes[i]) begin
      cfg_if.payload <= writes[i];
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    scr_w   = wshd_pkg::coord_t'(w);
    scr_h   = wshd_pkg::coord_t'(h);
    top_rsv = wshd_pkg::coord_t'(t);
  endtask

  // ---------------------------------------------------------------------
  // Report side: random gaps after each transfer, plus the long hold-off
  // that the stimulus asks for, counted down here.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : report_sink
    logic take;
    if (rsp_if.valid && rsp_if.ready) rsp_gap = steady ? 0 : $urandom_range(0, 3);
    if (rsp_hold > 0) begin
      rsp_hold--;
      take = 1'b0;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
      take = 1'b0;
    end else begin
      take = 1'b1;
    end
    rsp_if.ready <= take;
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      if (mismatches < 10)
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : report_checker
    wshd_pkg::rsp_t got, want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.payload;
      if (awaited_reports.size() == 0) begin
        if (mismatches < 10) $display("report with no request pending: 0x%0h", got);
        mismatches++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("event_code",   want.event_code,   got.event_code);
        check_field("window_index", want.window_index, got.window_index);
        check_field("new_x",        want.new_x,        got.new_x);
        check_field("new_y",        want.new_y,        got.new_y);
        check_field("old_x",        want.old_x,        got.old_x);
        check_field("old_y",        want.old_y,        got.old_y);
        check_field("erase_old",    want.erase_old,    got.erase_old);
        check_field("recomposite",  want.recomposite,  got.recomposite);
        check_field("stack_order",  want.stack_order,  got.stack_order);
        check_field("open_mask",    want.open_mask,    got.open_mask);
        check_field("owner_out",    want.owner_out,    got.owner_out);
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    rsp_if.ready   = 1'b0;
    reset_model();

    // Directed table. Rows with a typed report: state right after reset,
    // ignored requests and the first loads. The rest go to the predictor.
    plan(wshd_pkg::REQ_CLICK, 0, 0, 0, 0, 0, 0, 1'b1,
         report_of(wshd_pkg::EV_NONE, 0, 0, 0, 1'b0, ZORDER_RESET, 3'b000));   // background
    plan(wshd_pkg::REQ_DRAG, 4095, 4095, 0, 0, 0, 0, 1'b1,
         report_of(wshd_pkg::EV_NONE, 0, 0, 0, 1'b0, ZORDER_RESET, 3'b000));   // no drag yet
    plan(wshd_pkg::REQ_RELEASE, 0, 0, 0, 0, 0, 0, 1'b1,
         report_of(wshd_pkg::EV_NONE, 0, 0, 0, 1'b0, ZORDER_RESET, 3'b000));
    plan(wshd_pkg::REQ_REDRAW, 0, 0, 0, 0, 0, 0, 1'b1,
         report_of(wshd_pkg::EV_REDRAW, 0, 0, 0, 1'b1, ZORDER_RESET, 3'b000));
    plan(wshd_pkg::REQ_LOAD, 4095, 4095, wshd_pkg::WIN_COUNT, 4095, 4095, 'hFFFF, 1'b1,
         report_of(wshd_pkg::EV_NONE, 0, 0, 0, 1'b0, ZORDER_RESET, 3'b000));   // bad slot
    plan(REQ_UNUSED_LO, 4095, 4095, 3, 4095, 4095, 'hFFFF, 1'b1,
         report_of(wshd_pkg::EV_NONE, 0, 0, 0, 1'b0, ZORDER_RESET, 3'b000));
    plan(REQ_UNUSED_HI, 4095, 4095, 3, 4095, 4095, 'hFFFF, 1'b1,
         report_of(wshd_pkg::EV_NONE, 0, 0, 0, 1'b0, ZORDER_RESET, 3'b000));
    plan(wshd_pkg::REQ_LOAD, 100, 600, 0, 4095, 4095, 'hFFFF, 1'b1,
         report_of(wshd_pkg::EV_LOADED, 0, 100, 600, 1'b1, ZORDER_RESET, 3'b001)); // clamped
    plan(wshd_pkg::REQ_LOAD, 250, 0, 1, 0, 0, 0, 1'b1,
         report_of(wshd_pkg::EV_LOADED, 1, 250, 0, 1'b1, ZORDER_RESET, 3'b011)); // title y<0
    plan(wshd_pkg::REQ_LOAD, 4095, 4095, 2, 200, 150, 'h1234, 1'b1,
         report_of(wshd_pkg::EV_LOADED, 2, 4095, 4095, 1'b1, ZORDER_RESET, 3'b111));
    plan(wshd_pkg::REQ_CLICK, 150, 620);     // canvas of the bottom window: raise
    plan(wshd_pkg::REQ_CLICK, 100, 590);     // title of the top window: drag, no recomposite
    plan(wshd_pkg::REQ_DRAG, 0, 0);          // left clamp and reserved top
    plan(wshd_pkg::REQ_DRAG, 4095, 4095);    // right and bottom clamps
    plan(wshd_pkg::REQ_RELEASE, 0, 0);
    plan(wshd_pkg::REQ_CLICK, 1006, 600);    // close button of the moved window
    plan(wshd_pkg::REQ_CLICK, 300, 5);       // nothing hit
    plan(wshd_pkg::REQ_CLICK, 4095, 4095);   // far corner canvas
    plan(wshd_pkg::REQ_LOAD, 0, 20, 0, 199, 149, 'h8001);
    plan(wshd_pkg::REQ_CLICK, 0, 0);         // title starting at row 0
    plan(wshd_pkg::REQ_CLICK, 182, 2);       // close the dragged window: drag ends
    plan(wshd_pkg::REQ_DRAG, 500, 500);      // drag already gone
    plan(wshd_pkg::REQ_RELEASE, 0, 0);
    plan(wshd_pkg::REQ_REDRAW, 0, 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) send_request(script[i].rq, script[i].typed, script[i].want);

    // Random phases, each under its own screen setting. Phase 1 holds the
    // report side off long enough to back the block up; phase 2 drains in
    // the middle.
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      if (ph == 3)
        program_screen($urandom_range(200, 4095), $urandom_range(700, 4095),
                       $urandom_range(0, 2048));
      else
        program_screen(settings[ph][0], settings[ph][1], settings[ph][2]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        if (ph == 1 && n == 50) rsp_hold = 80;
        if (ph == 2 && n == 100) settle();
        send_request(pick_request(), 1'b0, '0);
      end
    end

    settle();
    repeat (12) @(posedge clk_i);   // catch any stray report
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
